FILE: design/scth_pkg.sv
package scth_pkg;

   localparam int MaxResults = 4;
   localparam int CountW     = $clog2(MaxResults + 1);
   localparam int PtrW       = $clog2(MaxResults);
   localparam int CsrAddrW   = 4;
   localparam int CsrDataW   = 32;

   localparam logic [7:0]  ACK_GOOD  = 8'd128;
   localparam logic [7:0]  ACK_BAD   = 8'd0;
   localparam logic [15:0] TICKS_MAX = 16'hFFFF;

   localparam logic [7:0]  GROUP_ID_RESET     = 8'd1;
   localparam logic [7:0]  COMMAND_CODE_RESET = 8'd1;
   localparam logic [7:0]  REQUEST_SIZE_RESET = 8'd0;
   localparam logic [15:0] RESEND_TICKS_RESET = 16'd500;

   typedef enum logic [1:0] {
      ACT_START = 2'd0,
      ACT_BYTE  = 2'd1,
      ACT_TICK  = 2'd2,
      ACT_NONE  = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      KIND_TX       = 2'd0,
      KIND_PAYLOAD  = 2'd1,
      KIND_DONE_OK  = 2'd2,
      KIND_DONE_ERR = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ERR_NONE        = 2'd0,
      ERR_BAD_ACK     = 2'd1,
      ERR_HEADER_SUM  = 2'd2,
      ERR_PAYLOAD_SUM = 2'd3
   } err_type;

   typedef enum logic [2:0] {
      PH_IDLE     = 3'd0,
      PH_WAIT_ACK = 3'd1,
      PH_HEADER   = 3'd2,
      PH_PAYLOAD  = 3'd3,
      PH_CHECKSUM = 3'd4
   } phase_type;

   typedef enum logic [1:0] {
      REG_GROUP_ID     = 2'd0,
      REG_COMMAND_CODE = 2'd1,
      REG_REQUEST_SIZE = 2'd2,
      REG_RESEND_TICKS = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic [7:0]  group_id;
      logic [7:0]  command_code;
      logic [7:0]  request_size;
      logic [15:0] resend_ticks;
   } cfg_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] data_byte;
      logic [7:0] payload_index;
      err_type    error_code;
   } result_type;

   typedef struct packed {
      result_type [MaxResults-1:0] item;
      logic [CountW-1:0]           count;
   } batch_type;

   typedef struct packed {
      logic in_valid;
      logic take;
      logic load;
   } eng_stat_type;

   typedef struct packed {
      logic              free;
      logic [CountW-1:0] count;
   } out_stat_type;

endpackage

FILE: design/scth_csr.sv
module scth_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [scth_pkg::CsrAddrW-1:0]    csr_paddr,
   input  logic [scth_pkg::CsrDataW-1:0]    csr_pwdata,
   output logic [scth_pkg::CsrDataW-1:0]    csr_prdata,
   output logic                             csr_pready,
   output scth_pkg::cfg_type                cfg
);
   import scth_pkg::*;

   cfg_type       cfg_ff, cfg_in;
   reg_index_type reg_sel;
   logic          wr_en;

   assign reg_sel    = reg_index_type'(csr_paddr[3:2]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_sel)
            REG_GROUP_ID:     cfg_in.group_id     = csr_pwdata[7:0];
            REG_COMMAND_CODE: cfg_in.command_code = csr_pwdata[7:0];
            REG_REQUEST_SIZE: cfg_in.request_size = csr_pwdata[7:0];
            REG_RESEND_TICKS: cfg_in.resend_ticks = csr_pwdata[15:0];
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_GROUP_ID:     csr_prdata = {24'd0, cfg_ff.group_id};
         REG_COMMAND_CODE: csr_prdata = {24'd0, cfg_ff.command_code};
         REG_REQUEST_SIZE: csr_prdata = {24'd0, cfg_ff.request_size};
         REG_RESEND_TICKS: csr_prdata = {16'd0, cfg_ff.resend_ticks};
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.group_id     <= GROUP_ID_RESET;
         cfg_ff.command_code <= COMMAND_CODE_RESET;
         cfg_ff.request_size <= REQUEST_SIZE_RESET;
         cfg_ff.resend_ticks <= RESEND_TICKS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

FILE: design/scth_engine.sv
module scth_engine (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [7:0]              req_tdata,
   input  logic [1:0]              req_tuser,
   input  scth_pkg::cfg_type       cfg,
   input  logic                    batch_free,
   output scth_pkg::batch_type     batch,
   output scth_pkg::eng_stat_type  stat
);
   import scth_pkg::*;

   logic       in_valid_ff, in_valid_in;
   action_type in_action_ff, in_action_in;
   logic [7:0] in_byte_ff, in_byte_in;

   phase_type  phase_ff, phase_in;
   logic [15:0] wait_ticks_ff, wait_ticks_in;
   logic [1:0] header_count_ff, header_count_in;
   logic [7:0] header_sum_ff, header_sum_in;
   logic [7:0] payload_length_ff, payload_length_in;
   logic [7:0] payload_received_ff, payload_received_in;
   logic [7:0] payload_sum_ff, payload_sum_in;

   logic        accept;
   logic        take;
   logic [15:0] wait_inc;
   logic        resend;
   logic [7:0]  recv_inc;
   logic [7:0]  sum_add;
   logic [7:0]  hdr_sum_add;

   function automatic result_type mk(kind_type k, logic [7:0] d, logic [7:0] idx,
                                     err_type e);
      result_type r;
      r.kind          = k;
      r.data_byte     = d;
      r.payload_index = idx;
      r.error_code    = e;
      return r;
   endfunction

   function automatic batch_type header_batch(cfg_type c);
      batch_type b;
      b         = '0;
      b.item[0] = mk(KIND_TX, c.group_id, 8'd0, ERR_NONE);
      b.item[1] = mk(KIND_TX, c.command_code, 8'd0, ERR_NONE);
      b.item[2] = mk(KIND_TX, c.request_size, 8'd0, ERR_NONE);
      b.item[3] = mk(KIND_TX, c.group_id + c.command_code + c.request_size, 8'd0,
                     ERR_NONE);
      b.count   = CountW'(4);
      return b;
   endfunction

   assign take       = in_valid_ff && batch_free;
   assign req_tready = !in_valid_ff || take;
   assign accept     = req_tvalid && req_tready;

   assign wait_inc    = (wait_ticks_ff != TICKS_MAX) ? wait_ticks_ff + 16'd1 : wait_ticks_ff;
   assign resend      = wait_inc >= cfg.resend_ticks;
   assign recv_inc    = payload_received_ff + 8'd1;
   assign sum_add     = payload_sum_ff + in_byte_ff;
   assign hdr_sum_add = header_sum_ff + in_byte_ff;

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_action_in = in_action_ff;
      in_byte_in   = in_byte_ff;
      if (accept) begin
         in_valid_in  = 1'b1;
         in_action_in = action_type'(req_tuser);
         in_byte_in   = req_tdata;
      end else if (take) begin
         in_valid_in = 1'b0;
      end
   end

   // next state
   always_comb begin
      phase_in            = phase_ff;
      wait_ticks_in       = wait_ticks_ff;
      header_count_in     = header_count_ff;
      header_sum_in       = header_sum_ff;
      payload_length_in   = payload_length_ff;
      payload_received_in = payload_received_ff;
      payload_sum_in      = payload_sum_ff;
      if (take) begin
         unique case (in_action_ff)
            ACT_START: begin
               phase_in            = PH_WAIT_ACK;
               wait_ticks_in       = 16'd0;
               header_count_in     = 2'd0;
               header_sum_in       = 8'd0;
               payload_length_in   = 8'd0;
               payload_received_in = 8'd0;
               payload_sum_in      = 8'd0;
            end
            ACT_BYTE: begin
               case (phase_ff)
                  PH_WAIT_ACK: begin
                     if (in_byte_ff == ACK_GOOD) begin
                        phase_in        = PH_HEADER;
                        header_count_in = 2'd0;
                        header_sum_in   = 8'd0;
                     end else begin
                        phase_in = PH_IDLE;
                     end
                  end
                  PH_HEADER: begin
                     priority if (header_count_ff == 2'd0) begin
                        header_sum_in   = in_byte_ff;
                        header_count_in = 2'd1;
                     end else if (header_count_ff == 2'd1) begin
                        payload_length_in = in_byte_ff;
                        header_sum_in     = hdr_sum_add;
                        header_count_in   = 2'd2;
                     end else begin
                        header_count_in = 2'd0;
                        if (in_byte_ff == header_sum_ff) begin
                           payload_received_in = 8'd0;
                           payload_sum_in      = 8'd0;
                           phase_in = (payload_length_ff == 8'd0) ? PH_CHECKSUM
                                                                  : PH_PAYLOAD;
                        end else begin
                           phase_in = PH_IDLE;
                        end
                     end
                  end
                  PH_PAYLOAD: begin
                     payload_sum_in      = sum_add;
                     payload_received_in = recv_inc;
                     if (recv_inc == payload_length_ff) begin
                        phase_in = PH_CHECKSUM;
                     end
                  end
                  PH_CHECKSUM: phase_in = PH_IDLE;
                  default: ;
               endcase
            end
            ACT_TICK: begin
               if (phase_ff == PH_WAIT_ACK) begin
                  wait_ticks_in = resend ? 16'd0 : wait_inc;
               end
            end
            ACT_NONE: ;
         endcase
      end
   end

   // result beats for this item
   always_comb begin
      batch = '0;
      unique case (in_action_ff)
         ACT_START: batch = header_batch(cfg);
         ACT_BYTE: begin
            case (phase_ff)
               PH_WAIT_ACK: begin
                  if (in_byte_ff != ACK_GOOD) begin
                     batch.item[0] = mk(KIND_DONE_ERR, 8'd0, 8'd0, ERR_BAD_ACK);
                     batch.count   = CountW'(1);
                  end
               end
               PH_HEADER: begin
                  if (header_count_ff != 2'd0 && header_count_ff != 2'd1) begin
                     if (in_byte_ff == header_sum_ff) begin
                        batch.item[0] = mk(KIND_TX, ACK_GOOD, 8'd0, ERR_NONE);
                        batch.count   = CountW'(1);
                     end else begin
                        batch.item[0] = mk(KIND_TX, ACK_BAD, 8'd0, ERR_NONE);
                        batch.item[1] = mk(KIND_DONE_ERR, 8'd0, 8'd0, ERR_HEADER_SUM);
                        batch.count   = CountW'(2);
                     end
                  end
               end
               PH_PAYLOAD: begin
                  batch.item[0] = mk(KIND_PAYLOAD, in_byte_ff, payload_received_ff,
                                     ERR_NONE);
                  batch.count   = CountW'(1);
               end
               PH_CHECKSUM: begin
                  if (in_byte_ff == payload_sum_ff) begin
                     batch.item[0] = mk(KIND_TX, ACK_GOOD, 8'd0, ERR_NONE);
                     batch.item[1] = mk(KIND_DONE_OK, 8'd0, 8'd0, ERR_NONE);
                  end else begin
                     batch.item[0] = mk(KIND_TX, ACK_BAD, 8'd0, ERR_NONE);
                     batch.item[1] = mk(KIND_DONE_ERR, 8'd0, 8'd0, ERR_PAYLOAD_SUM);
                  end
                  batch.count = CountW'(2);
               end
               default: ;
            endcase
         end
         ACT_TICK: begin
            if (phase_ff == PH_WAIT_ACK && resend) begin
               batch = header_batch(cfg);
            end
         end
         ACT_NONE: ;
      endcase
   end

   assign stat.in_valid = in_valid_ff;
   assign stat.take     = take;
   assign stat.load     = take && (batch.count != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff         <= 1'b0;
         phase_ff            <= PH_IDLE;
         wait_ticks_ff       <= 16'd0;
         header_count_ff     <= 2'd0;
         header_sum_ff       <= 8'd0;
         payload_length_ff   <= 8'd0;
         payload_received_ff <= 8'd0;
         payload_sum_ff      <= 8'd0;
      end else begin
         in_valid_ff         <= in_valid_in;
         phase_ff            <= phase_in;
         wait_ticks_ff       <= wait_ticks_in;
         header_count_ff     <= header_count_in;
         header_sum_ff       <= header_sum_in;
         payload_length_ff   <= payload_length_in;
         payload_received_ff <= payload_received_in;
         payload_sum_ff      <= payload_sum_in;
      end
   end

   always_ff @(posedge clock) begin
      in_action_ff <= in_action_in;
      in_byte_ff   <= in_byte_in;
   end

endmodule

FILE: design/scth_out.sv
module scth_out (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  scth_pkg::batch_type    batch,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [23:0]            rsp_tdata,
   output logic [1:0]             rsp_tuser,
   output logic                   rsp_tlast,
   output scth_pkg::out_stat_type stat
);
   import scth_pkg::*;

   result_type [MaxResults-1:0] item_ff, item_in;
   logic [CountW-1:0]           count_ff, count_in;
   logic [PtrW-1:0]             ptr_ff, ptr_in;
   result_type                  cur;
   logic                        at_last;
   logic                        beat;

   assign cur        = item_ff[ptr_ff];
   assign at_last    = (CountW'(ptr_ff) + CountW'(1)) == count_ff;
   assign rsp_tvalid = count_ff != '0;
   assign beat       = rsp_tvalid && rsp_tready;
   assign rsp_tdata  = {6'd0, cur.error_code, cur.payload_index, cur.data_byte};
   assign rsp_tuser  = cur.kind;
   assign rsp_tlast  = at_last;

   assign stat.free  = !rsp_tvalid || (beat && at_last);
   assign stat.count = count_ff;

   always_comb begin
      item_in  = item_ff;
      count_in = count_ff;
      ptr_in   = ptr_ff;
      if (load) begin
         item_in  = batch.item;
         count_in = batch.count;
         ptr_in   = '0;
      end else if (beat) begin
         if (at_last) begin
            count_in = '0;
            ptr_in   = '0;
         end else begin
            ptr_in = ptr_ff + PtrW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         ptr_ff   <= '0;
      end else begin
         count_ff <= count_in;
         ptr_ff   <= ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

endmodule

FILE: design/serial_command_transaction_host.sv
// host side of a framed serial command exchange
// req channel: one beat per event; tuser = action (0 start, 1 received byte,
// 2 time tick), tdata = received byte. rsp channel: transmit bytes, delivered
// payload bytes and a finished ok/error beat; tuser = kind, tlast marks the
// final beat caused by one request beat.
// csr port: group_id 0x0, command_code 0x4, request_size 0x8, resend_ticks 0xc.
// a request beat is registered in the input register, its results are computed
// from it and loaded into the result buffer, which presents the response beats.
// throughput: one request beat per cycle while rsp_tready is high and each
// produces at most one response beat; a start or resend produces four beats,
// a header checksum failure or a payload checksum two; the next request waits
// in the input register until the four-entry buffer drains to its last beat.
// a request that produces no result (ack byte, idle bytes, ticks) still passes
// through the input register.
// reset clears the transaction state to idle, drops buffered beats and loads
// the register defaults; when the receiver stalls the current beat holds and
// at most one further request beat is taken into the input register.
module serial_command_transaction_host (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [7:0]                            req_tdata,  // rx_byte[7:0]
   input  logic [1:0]                            req_tuser,  // action[1:0]
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // data_byte[7:0], payload_index[15:8], error_code[17:16], zero[23:18]
   output logic [23:0]                           rsp_tdata,
   output logic [1:0]                            rsp_tuser,  // kind[1:0]
   output logic                                  rsp_tlast,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [scth_pkg::CsrAddrW-1:0]         csr_paddr,
   input  logic [scth_pkg::CsrDataW-1:0]         csr_pwdata,
   output logic [scth_pkg::CsrDataW-1:0]         csr_prdata,
   output logic                                  csr_pready
);
   import scth_pkg::*;

   cfg_type      cfg;
   batch_type    batch;
   eng_stat_type eng_stat;
   out_stat_type out_stat;

   scth_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   scth_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cfg        (cfg),
      .batch_free (out_stat.free),
      .batch      (batch),
      .stat       (eng_stat)
   );

   scth_out u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (eng_stat.load),
      .batch      (batch),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .stat       (out_stat)
   );

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      out_stat.count <= CountW'(MaxResults))
      else $error("result buffer count out of range");

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      eng_stat.load |-> out_stat.free)
      else $error("result buffer overwritten before drained");

   a_hold_when_blocked: assert property (@(posedge clock) disable iff (reset)
      (eng_stat.in_valid && !eng_stat.take) |=> eng_stat.in_valid)
      else $error("pending request lost while result buffer busy");

   a_load_shows_beat: assert property (@(posedge clock) disable iff (reset)
      eng_stat.load |=> rsp_tvalid)
      else $error("loaded results not presented");

endmodule

FILE: bench/serial_command_transaction_host_test.sv
`timescale 1ns / 1ps

module serial_command_transaction_host_test;
   import scth_pkg::*;

   localparam int CycleLimit   = 200000;
   localparam int ItemTarget   = 310;
   localparam int SettleCycles = 8;
   localparam int IdlePercent  = 14;
   localparam int DrainLimit   = 2000;

   typedef struct packed {
      result_type fields;
      logic       last;
   } host_beat_type;

   logic                clock;
   logic                reset       = 1'b1;
   logic                req_tvalid  = 1'b0;
   logic                req_tready;
   logic [7:0]          req_tdata   = '0;  // rx_byte[7:0]
   logic [1:0]          req_tuser   = '0;  // action[1:0]
   logic                rsp_tvalid;
   logic                rsp_tready  = 1'b0;
   // data_byte[7:0], payload_index[15:8], error_code[17:16], zero[23:18]
   logic [23:0]         rsp_tdata;
   logic [1:0]          rsp_tuser;  // kind[1:0]
   logic                rsp_tlast;
   logic                csr_psel    = 1'b0;
   logic                csr_penable = 1'b0;
   logic                csr_pwrite  = 1'b0;
   logic [CsrAddrW-1:0] csr_paddr   = '0;
   logic [CsrDataW-1:0] csr_pwdata  = '0;
   logic [CsrDataW-1:0] csr_prdata;
   logic                csr_pready;

   // host model state
   cfg_type     reg_model;
   phase_type   host_phase;
   logic [15:0] tick_count;
   logic [1:0]  hdr_count;
   logic [7:0]  hdr_sum;
   logic [7:0]  frame_len;
   logic [7:0]  frame_got;
   logic [7:0]  frame_sum;

   host_beat_type expected_beats[$];
   host_beat_type head_beat;
   int            items_sent  = 0;
   int            fails       = 0;
   int            cycle_count = 0;
   bit            steady      = 1'b0;

   serial_command_transaction_host dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_tready <= steady || ($urandom_range(99) >= IdlePercent);
   end

   function automatic void expect_beat(kind_type k, logic [7:0] d, logic [7:0] idx,
                                       err_type e);
      host_beat_type beat;
      beat.fields.kind          = k;
      beat.fields.data_byte     = d;
      beat.fields.payload_index = idx;
      beat.fields.error_code    = e;
      beat.last                 = 1'b0;
      expected_beats.push_back(beat);
   endfunction

   function automatic void expect_header();
      logic [7:0] sum;
      sum = reg_model.group_id + reg_model.command_code + reg_model.request_size;
      expect_beat(KIND_TX, reg_model.group_id, 8'd0, ERR_NONE);
      expect_beat(KIND_TX, reg_model.command_code, 8'd0, ERR_NONE);
      expect_beat(KIND_TX, reg_model.request_size, 8'd0, ERR_NONE);
      expect_beat(KIND_TX, sum, 8'd0, ERR_NONE);
   endfunction

   // advances the host model by one event; returns 0 when the event is ignored
   function automatic bit host_event(action_type act, logic [7:0] b);
      int first;
      bit used;
      first = expected_beats.size();
      used  = 1'b1;
      case (act)
         ACT_START: begin
            host_phase = PH_WAIT_ACK;
            tick_count = '0;
            hdr_count  = '0;
            hdr_sum    = '0;
            frame_len  = '0;
            frame_got  = '0;
            frame_sum  = '0;
            expect_header();
         end
         ACT_BYTE: begin
            case (host_phase)
               PH_WAIT_ACK: begin
                  if (b == ACK_GOOD) begin
                     host_phase = PH_HEADER;
                     hdr_count  = '0;
                     hdr_sum    = '0;
                  end else begin
                     expect_beat(KIND_DONE_ERR, 8'd0, 8'd0, ERR_BAD_ACK);
                     host_phase = PH_IDLE;
                  end
               end
               PH_HEADER: begin
                  if (hdr_count == 2'd0) begin
                     hdr_sum   = b;
                     hdr_count = 2'd1;
                  end else if (hdr_count == 2'd1) begin
                     frame_len = b;
                     hdr_sum   = hdr_sum + b;
                     hdr_count = 2'd2;
                  end else begin
                     hdr_count = 2'd0;
                     if (b == hdr_sum) begin
                        expect_beat(KIND_TX, ACK_GOOD, 8'd0, ERR_NONE);
                        frame_got  = '0;
                        frame_sum  = '0;
                        host_phase = (frame_len == 8'd0) ? PH_CHECKSUM : PH_PAYLOAD;
                     end else begin
                        expect_beat(KIND_TX, ACK_BAD, 8'd0, ERR_NONE);
                        expect_beat(KIND_DONE_ERR, 8'd0, 8'd0, ERR_HEADER_SUM);
                        host_phase = PH_IDLE;
                     end
                  end
               end
               PH_PAYLOAD: begin
                  expect_beat(KIND_PAYLOAD, b, frame_got, ERR_NONE);
                  frame_sum = frame_sum + b;
                  frame_got = frame_got + 8'd1;
                  if (frame_got == frame_len) host_phase = PH_CHECKSUM;
               end
               PH_CHECKSUM: begin
                  if (b == frame_sum) begin
                     expect_beat(KIND_TX, ACK_GOOD, 8'd0, ERR_NONE);
                     expect_beat(KIND_DONE_OK, 8'd0, 8'd0, ERR_NONE);
                  end else begin
                     expect_beat(KIND_TX, ACK_BAD, 8'd0, ERR_NONE);
                     expect_beat(KIND_DONE_ERR, 8'd0, 8'd0, ERR_PAYLOAD_SUM);
                  end
                  host_phase = PH_IDLE;
               end
               default: used = 1'b0;
            endcase
         end
         ACT_TICK: begin
            if (host_phase == PH_WAIT_ACK) begin
               if (tick_count != TICKS_MAX) tick_count = tick_count + 16'd1;
               if (tick_count >= reg_model.resend_ticks) begin
                  tick_count = '0;
                  expect_header();
               end
            end else begin
               used = 1'b0;
            end
         end
         default: used = 1'b0;
      endcase
      if (expected_beats.size() > first)
         expected_beats[expected_beats.size()-1].last = 1'b1;
      return used;
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_beats.size() == 0) begin
            $error("unexpected beat: kind %0d, data %0h", rsp_tuser, rsp_tdata[7:0]);
            fails++;
         end else begin
            head_beat = expected_beats.pop_front();
            if (rsp_tuser !== head_beat.fields.kind) begin
               $error("kind: expected %0d, got %0d", head_beat.fields.kind, rsp_tuser);
               fails++;
            end
            if (rsp_tdata[7:0] !== head_beat.fields.data_byte) begin
               $error("data_byte: expected %0h, got %0h", head_beat.fields.data_byte,
                      rsp_tdata[7:0]);
               fails++;
            end
            if (rsp_tdata[15:8] !== head_beat.fields.payload_index) begin
               $error("payload_index: expected %0d, got %0d",
                      head_beat.fields.payload_index, rsp_tdata[15:8]);
               fails++;
            end
            if (rsp_tdata[17:16] !== head_beat.fields.error_code) begin
               $error("error_code: expected %0d, got %0d", head_beat.fields.error_code,
                      rsp_tdata[17:16]);
               fails++;
            end
            if (rsp_tlast !== head_beat.last) begin
               $error("last: expected %0b, got %0b", head_beat.last, rsp_tlast);
               fails++;
            end
         end
      end
   end

   // called at a falling edge, returns at a falling edge with the beat taken
   task automatic send_event(action_type act, logic [7:0] b);
      while (!steady && $urandom_range(99) < IdlePercent) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= b;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (host_event(act, b)) items_sent++;
      @(negedge clock);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (expected_beats.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_reg(reg_index_type r, logic [31:0] v);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= {r, 2'b00};
      csr_pwdata  <= v;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      case (r)
         REG_GROUP_ID:     reg_model.group_id     = v[7:0];
         REG_COMMAND_CODE: reg_model.command_code = v[7:0];
         REG_REQUEST_SIZE: reg_model.request_size = v[7:0];
         REG_RESEND_TICKS: reg_model.resend_ticks = v[15:0];
         default: ;
      endcase
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
   endtask

   function automatic logic [7:0] pick_byte();
      int r;
      r = $urandom_range(99);
      if (r < 15) return 8'h00;
      if (r < 30) return 8'hff;
      return 8'($urandom);
   endfunction

   task automatic pick_settings();
      logic [15:0] ticks;
      case ($urandom_range(9))
         0:       ticks = 16'd1;
         1:       ticks = 16'hffff;
         2, 3:    ticks = 16'($urandom_range(7, 600));
         default: ticks = 16'($urandom_range(1, 6));
      endcase
      write_reg(REG_GROUP_ID, 32'(pick_byte()));
      write_reg(REG_COMMAND_CODE, 32'(pick_byte()));
      write_reg(REG_REQUEST_SIZE, 32'(pick_byte()));
      write_reg(REG_RESEND_TICKS, 32'(ticks));
   endtask

   function automatic logic [7:0] not_ack();
      logic [7:0] v;
      v = 8'($urandom_range(0, 254));
      if (v >= ACK_GOOD) v = v + 8'd1;
      return v;
   endfunction

   // one exchange with random content, mostly well formed
   task automatic run_frame();
      logic [7:0] b0, len, sum, b;
      int         n_ticks, r;
      send_event(ACT_START, 8'($urandom));
      if (reg_model.resend_ticks <= 16'd8)
         n_ticks = $urandom_range(0, 2 * reg_model.resend_ticks);
      else
         n_ticks = $urandom_range(0, 2);
      repeat (n_ticks) send_event(ACT_TICK, 8'($urandom));
      if ($urandom_range(99) < 8) begin
         send_event(ACT_BYTE, not_ack());
         return;
      end
      send_event(ACT_BYTE, ACK_GOOD);
      b0 = 8'($urandom);
      r  = $urandom_range(99);
      if (r < 60)      len = 8'($urandom_range(0, 6));
      else if (r < 95) len = 8'($urandom_range(7, 24));
      else             len = 8'($urandom_range(25, 40));
      sum = b0 + len;
      if ($urandom_range(99) < 15) sum = sum + 8'($urandom_range(1, 255));
      send_event(ACT_BYTE, b0);
      send_event(ACT_BYTE, len);
      send_event(ACT_BYTE, sum);
      if (sum != b0 + len) return;
      sum = '0;
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(99) < 3) return;
         if ($urandom_range(99) < 5) send_event(ACT_TICK, 8'($urandom));
         b   = 8'($urandom);
         sum = sum + b;
         send_event(ACT_BYTE, b);
      end
      if ($urandom_range(99) < 15) sum = sum ^ 8'($urandom_range(1, 255));
      send_event(ACT_BYTE, sum);
   endtask

   // default header, resend after lowering the threshold, bad ack, idle events
   task automatic test_default_header();
      send_event(ACT_START, 8'h00);
      send_event(ACT_TICK, 8'h00);
      wait_idle();
      write_reg(REG_RESEND_TICKS, 32'd1);
      send_event(ACT_TICK, 8'h00);
      send_event(ACT_BYTE, 8'h05);
      send_event(ACT_BYTE, ACK_GOOD);
      send_event(ACT_TICK, 8'h00);
      send_event(ACT_NONE, 8'hff);
   endtask

   // zero threshold resends on the first tick, empty payload
   task automatic test_empty_payload();
      wait_idle();
      write_reg(REG_GROUP_ID, 32'd0);
      write_reg(REG_COMMAND_CODE, 32'd0);
      write_reg(REG_REQUEST_SIZE, 32'd0);
      write_reg(REG_RESEND_TICKS, 32'd0);
      send_event(ACT_START, 8'h00);
      send_event(ACT_TICK, 8'h00);
      send_event(ACT_BYTE, ACK_GOOD);
      send_event(ACT_BYTE, 8'h12);
      send_event(ACT_BYTE, 8'h00);
      send_event(ACT_BYTE, 8'h12);
      send_event(ACT_BYTE, 8'h00);
   endtask

   // all-ones header, long threshold, payload checksum failure
   task automatic test_extreme_config();
      wait_idle();
      write_reg(REG_GROUP_ID, 32'hff);
      write_reg(REG_COMMAND_CODE, 32'hff);
      write_reg(REG_REQUEST_SIZE, 32'hff);
      write_reg(REG_RESEND_TICKS, 32'hffff);
      send_event(ACT_START, 8'hff);
      send_event(ACT_TICK, 8'hff);
      send_event(ACT_BYTE, ACK_GOOD);
      send_event(ACT_BYTE, 8'hff);
      send_event(ACT_BYTE, 8'h02);
      send_event(ACT_BYTE, 8'h01);
      send_event(ACT_BYTE, 8'h80);
      send_event(ACT_BYTE, 8'h7f);
      send_event(ACT_BYTE, 8'h00);
   endtask

   // start in the middle of a payload, then a bad header checksum
   task automatic test_restart();
      send_event(ACT_START, 8'h00);
      send_event(ACT_BYTE, ACK_GOOD);
      send_event(ACT_BYTE, 8'h00);
      send_event(ACT_BYTE, 8'h02);
      send_event(ACT_BYTE, 8'h02);
      send_event(ACT_BYTE, 8'h55);
      send_event(ACT_START, 8'h55);
      send_event(ACT_BYTE, ACK_GOOD);
      send_event(ACT_BYTE, 8'h01);
      send_event(ACT_BYTE, 8'h02);
      send_event(ACT_BYTE, 8'h00);
   endtask

   task automatic test_random_traffic();
      int frame_no;
      frame_no = 0;
      while (items_sent < ItemTarget) begin
         if (frame_no % 6 == 0) begin
            wait_idle();
            pick_settings();
         end
         steady = (frame_no >= 10 && frame_no < 16);
         if ($urandom_range(99) < 12)
            send_event(action_type'($urandom_range(0, 3)), 8'($urandom));
         else
            run_frame();
         frame_no++;
      end
      steady = 1'b0;
   endtask

   initial begin
      int spin;
      reg_model  = {GROUP_ID_RESET, COMMAND_CODE_RESET, REQUEST_SIZE_RESET,
                    RESEND_TICKS_RESET};
      host_phase = PH_IDLE;
      tick_count = '0;
      hdr_count  = '0;
      hdr_sum    = '0;
      frame_len  = '0;
      frame_got  = '0;
      frame_sum  = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_default_header();
      test_empty_payload();
      test_extreme_config();
      test_restart();
      test_random_traffic();

      req_tvalid <= 1'b0;
      spin = 0;
      while (expected_beats.size() != 0 && spin < DrainLimit) begin
         @(posedge clock);
         spin++;
      end
      repeat (SettleCycles) @(posedge clock);
      if (expected_beats.size() != 0) begin
         $error("%0d expected beats never arrived", expected_beats.size());
         fails++;
      end
      if (fails == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
